/* rtl/core/dmc_pkg.sv */
// Types and constants shared by the DHCP message classifier.
// This package has no dependencies. dmc_step and dhcp_message_classifier import it.
package dmc_pkg;

	// Phases of the per-datagram parse walk
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_CODE   = 3'd1;
	localparam logic [2:0] PH_LEN    = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	localparam logic [7:0] HDR_LAST_BYTE = 8'd239;
	localparam logic [7:0] MAGIC_AT      = 8'd236;

	localparam logic [15:0] PORT_V4_SERVER = 16'd67;
	localparam logic [15:0] PORT_V4_CLIENT = 16'd68;
	localparam logic [15:0] PORT_V6_CLIENT = 16'd546;
	localparam logic [15:0] PORT_V6_SERVER = 16'd547;

	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_LEASE    = 8'd51;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_RENEW    = 8'd58;
	localparam logic [7:0] OPT_REBIND   = 8'd59;
	localparam logic [7:0] OPT_END      = 8'd255;
	localparam logic [7:0] TIME_OPT_LEN = 8'd4;

	// DHCPv4 message type codes
	localparam logic [7:0] V4_DISCOVER = 8'd1;
	localparam logic [7:0] V4_OFFER    = 8'd2;
	localparam logic [7:0] V4_REQUEST  = 8'd3;
	localparam logic [7:0] V4_ACK      = 8'd5;
	// DHCPv6 message type codes
	localparam logic [7:0] V6_SOLICIT  = 8'd1;
	localparam logic [7:0] V6_RENEW    = 8'd5;
	localparam logic [7:0] V6_REPLY    = 8'd7;

	// Result kinds
	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_ACK      = 3'd1;
	localparam logic [2:0] KIND_DISCOVER = 3'd2;
	localparam logic [2:0] KIND_OFFER    = 3'd3;
	localparam logic [2:0] KIND_REQUEST  = 3'd4;
	localparam logic [2:0] KIND_SOLICIT  = 3'd5;
	localparam logic [2:0] KIND_REPLY    = 3'd6;
	localparam logic [2:0] KIND_RENEW    = 3'd7;

	localparam logic [31:0] DEFAULT_EXPIRE_RESET = 32'd86400;

	typedef struct packed {
		logic [7:0]  header_offset;
		logic [2:0]  parse_phase;
		logic        packet_ok;
		logic [7:0]  option_code;
		logic [7:0]  option_length;
		logic [7:0]  bytes_left;
		logic [31:0] value_shift;
		logic        option_pending;
		logic [7:0]  message_type;
		logic [31:0] lease_value;
		logic [31:0] rebind_value;
		logic [31:0] renew_value;
		logic [7:0]  first_data;
		logic        v6_packet;
		logic        in_packet;
	} parse_state_t;

	typedef struct packed {
		logic [2:0]  msg_kind;
		logic        expire_valid;
		logic [31:0] expire_seconds;
	} result_t;

	localparam parse_state_t STATE_CLEAR = '{
		header_offset:  8'd0,
		parse_phase:    PH_HEADER,
		packet_ok:      1'b1,
		option_code:    8'd0,
		option_length:  8'd0,
		bytes_left:     8'd0,
		value_shift:    32'd0,
		option_pending: 1'b0,
		message_type:   8'd0,
		lease_value:    32'd0,
		rebind_value:   32'd0,
		renew_value:    32'd0,
		first_data:     8'd0,
		v6_packet:      1'b0,
		in_packet:      1'b0
	};

	// Magic cookie 0x63825363, one byte per header position
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = 8'h63;
			2'd1: m = 8'h82;
			2'd2: m = 8'h53;
			2'd3: m = 8'h63;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

/* rtl/core/dmc_step.sv */
// One-byte update of the DHCP parse state, and the result for a last byte.
// Depends on dmc_pkg. This module is pure combinational logic, and the top level holds the registers.
module dmc_step (
	input  dmc_pkg::parse_state_t cur,
	input  logic [7:0]            byte_value,
	input  logic                  last_byte,
	input  logic [15:0]           udp_port,
	input  logic                  is_ipv6,
	input  logic [31:0]           default_expire,
	output dmc_pkg::parse_state_t nxt,
	output dmc_pkg::result_t      res
);
	import dmc_pkg::*;

	parse_state_t base;
	parse_state_t upd;
	logic [7:0]   left_dec;
	logic         port_v4_ok;
	logic         port_v6_ok;

	assign port_v4_ok = (udp_port == PORT_V4_SERVER) || (udp_port == PORT_V4_CLIENT);
	assign port_v6_ok = (udp_port == PORT_V6_CLIENT) || (udp_port == PORT_V6_SERVER);
	assign left_dec   = base.bytes_left - 8'd1;

	// A first byte starts from the cleared state, with the family and port check latched
	always_comb begin
		if (cur.in_packet) begin
			base = cur;
		end else begin
			base           = STATE_CLEAR;
			base.in_packet = 1'b1;
			base.v6_packet = is_ipv6;
			base.packet_ok = is_ipv6 ? port_v6_ok : port_v4_ok;
		end
	end

	always_comb begin
		upd = base;
		if (base.v6_packet) begin
			if (!cur.in_packet) begin
				upd.message_type = byte_value;
				upd.parse_phase  = PH_DONE;
			end
		end else begin
			unique case (base.parse_phase)
				PH_HEADER: begin
					if (base.header_offset >= MAGIC_AT &&
					    byte_value != magic_byte(2'(base.header_offset - MAGIC_AT)))
						upd.packet_ok = 1'b0;
					if (base.header_offset == HDR_LAST_BYTE)
						upd.parse_phase = PH_CODE;
					else
						upd.header_offset = base.header_offset + 8'd1;
				end
				PH_CODE: begin
					if (base.option_pending) begin
						upd.option_pending = 1'b0;
						if (base.option_code == OPT_MSG_TYPE) begin
							if (base.option_length != 8'd0)
								upd.message_type = base.first_data;
						end else if (base.option_length == TIME_OPT_LEN) begin
							if (base.option_code == OPT_LEASE)
								upd.lease_value = base.value_shift;
							else if (base.option_code == OPT_REBIND)
								upd.rebind_value = base.value_shift;
							else if (base.option_code == OPT_RENEW)
								upd.renew_value = base.value_shift;
						end
					end
					if (byte_value == OPT_END) begin
						upd.parse_phase = PH_DONE;
					end else if (byte_value != OPT_PAD) begin
						upd.option_code = byte_value;
						upd.parse_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					upd.option_length = byte_value;
					upd.bytes_left    = byte_value;
					upd.value_shift   = 32'd0;
					upd.first_data    = 8'd0;
					if (byte_value == 8'd0) begin
						upd.option_pending = 1'b1;
						upd.parse_phase    = PH_CODE;
					end else begin
						upd.parse_phase = PH_DATA;
					end
				end
				PH_DATA: begin
					if (base.bytes_left == base.option_length)
						upd.first_data = byte_value;
					upd.value_shift = {base.value_shift[23:0], byte_value};
					upd.bytes_left  = left_dec;
					if (left_dec == 8'd0) begin
						upd.option_pending = 1'b1;
						upd.parse_phase    = PH_CODE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// After a last byte only in_packet matters; the rest is rebuilt on the next first byte
	always_comb begin
		nxt = upd;
		if (last_byte)
			nxt = STATE_CLEAR;
	end

	always_comb begin
		res = '{msg_kind: KIND_NONE, expire_valid: 1'b0, expire_seconds: 32'd0};
		if (upd.v6_packet) begin
			if (upd.packet_ok) begin
				priority if (upd.message_type == V6_SOLICIT) res.msg_kind = KIND_SOLICIT;
				else if (upd.message_type == V6_REPLY)       res.msg_kind = KIND_REPLY;
				else if (upd.message_type == V6_RENEW)       res.msg_kind = KIND_RENEW;
			end
		end else if (upd.packet_ok && upd.parse_phase != PH_HEADER) begin
			res.expire_valid = 1'b1;
			priority if (upd.renew_value != 32'd0)  res.expire_seconds = upd.renew_value;
			else if (upd.rebind_value != 32'd0)     res.expire_seconds = upd.rebind_value;
			else if (upd.lease_value != 32'd0)      res.expire_seconds = upd.lease_value;
			else                                    res.expire_seconds = default_expire;
			priority if (upd.message_type == V4_ACK)  res.msg_kind = KIND_ACK;
			else if (upd.message_type == V4_DISCOVER) res.msg_kind = KIND_DISCOVER;
			else if (upd.message_type == V4_OFFER)    res.msg_kind = KIND_OFFER;
			else if (upd.message_type == V4_REQUEST)  res.msg_kind = KIND_REQUEST;
		end
	end

endmodule

/* rtl/core/dhcp_message_classifier.sv */
// Top level of the DHCP message classifier: input register, parse state and result register.
// Depends on dmc_pkg and dmc_step.
//
// The block takes a UDP payload one byte per request, with udp_port and is_ipv6 sampled on
// the first byte. It gives exactly one result request on the byte marked last_byte.
// DHCPv4 needs port 67 or 68, at least 240 header bytes and the magic cookie at bytes 236 to
// 239. The block then walks the options and picks up the message type (53) and the lease
// (51), renew (58) and rebind (59) times, with a later option overriding an earlier one.
// An option whose data ends on the final byte is not applied. expire_seconds is the first
// nonzero value of renew, rebind and lease, or else default_expire_seconds as written through
// cfg_we/cfg_wdata (86400 after reset). DHCPv6 needs port 546 or 547 and classifies the first
// byte only. A rejected datagram gives kind none with expire_valid and expire_seconds at zero.
// Throughput: one byte per clock, sustained while no last byte is held back. Each byte sits in
// the input register and is folded into the parse state at the edge that moves it on. A last byte
// also loads the result register at that edge, which raises out_valid. out_stall holds back only
// a last byte that meets a full result register. Ordinary bytes keep flowing while a result waits,
// and there is no reset sweep.
module dhcp_message_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// byte requests
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic [15:0] udp_port,
	input  logic        is_ipv6,
	// result requests
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  msg_kind,
	output logic        expire_valid,
	output logic [31:0] expire_seconds,
	// configuration: default_expire_seconds
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import dmc_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_value_s1;
	logic        last_byte_s1;
	logic [15:0] udp_port_s1;
	logic        is_ipv6_s1;

	logic [31:0]  default_expire_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      res_nxt;

	logic    out_valid_q;
	result_t result_q;

	logic in_accept;
	logic out_free;
	logic process;
	logic emit;

	// The result slot is free if it is empty, or if it drains this edge
	assign out_free  = !out_valid_q || !out_stall;
	// The held byte moves on unless it is a last byte that finds the result slot occupied
	assign process   = valid_s1 && (!last_byte_s1 || out_free);
	assign emit      = process && last_byte_s1;
	assign in_stall  = valid_s1 && !process;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (process)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_value_s1 <= byte_value;
			last_byte_s1  <= last_byte;
			udp_port_s1   <= udp_port;
			is_ipv6_s1    <= is_ipv6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_expire_q <= DEFAULT_EXPIRE_RESET;
		end else if (cfg_we) begin
			default_expire_q <= cfg_wdata;
		end
	end

	dmc_step u_step (
		.cur            (state_q),
		.byte_value     (byte_value_s1),
		.last_byte      (last_byte_s1),
		.udp_port       (udp_port_s1),
		.is_ipv6        (is_ipv6_s1),
		.default_expire (default_expire_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (process) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			result_q <= res_nxt;
	end

	assign out_valid      = out_valid_q;
	assign msg_kind       = result_q.msg_kind;
	assign expire_valid   = result_q.expire_valid;
	assign expire_seconds = result_q.expire_seconds;

	// A last byte closes its datagram
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !state_q.in_packet)
		else $error("parse state still open after a last byte");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("result register overwritten while stalled");

	// An expiry comes only with a DHCPv4 kind
	a_v4_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.expire_valid) |->
		(result_q.msg_kind != KIND_SOLICIT && result_q.msg_kind != KIND_REPLY &&
		 result_q.msg_kind != KIND_RENEW))
		else $error("expiry reported with a DHCPv6 kind");

	// Without a checked header, no expiry value is reported
	a_expire_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_q.expire_valid) |-> result_q.expire_seconds == 32'd0)
		else $error("expiry value without a valid DHCPv4 header");

endmodule

/* test/testbench.sv */
// Self-checking bench for dhcp_message_classifier: a directed table of datagrams, then random
// phases with varied sender gaps, receiver stalls and default expiry settings.
// Depends on dmc_pkg and the dhcp_message_classifier RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dmc_pkg::*;

	localparam logic [31:0] COOKIE   = 32'h6382_5363;
	localparam logic [8:0]  FULL_HDR = 9'd240;
	localparam result_t     REJECTED = '0;

	// One byte request as it goes to the block, with an optional hand-typed result for the
	// datagram it closes.
	typedef struct packed {
		logic [7:0]  b;
		logic        last;
		logic [15:0] port;
		logic        v6;
		logic        typed;
		result_t     want;
	} byte_req_t;

	// Our own copy of the per-datagram parse state.
	typedef struct packed {
		logic [7:0]  pos;
		logic [2:0]  step;
		logic        ok;
		logic [7:0]  code;
		logic [7:0]  len;
		logic [7:0]  left_n;
		logic [31:0] acc;
		logic        pending;
		logic [7:0]  mtype;
		logic [31:0] lease;
		logic [31:0] rebind;
		logic [31:0] renew;
		logic [7:0]  lead;
		logic        v6;
		logic        busy;
	} walk_t;

	// Directed datagram: option bytes are packed with the first byte highest.
	typedef struct packed {
		logic         v6;
		logic [15:0]  port;
		logic [8:0]   hdr_len;
		logic         cookie_ok;
		logic [5:0]   n_opt;
		logic [255:0] opts;
		logic         typed;
		result_t      want;
	} plan_row_t;

	typedef enum {INTACT, SHORT, WRONG_PORT, BAD_COOKIE} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_value = 8'd0;
	logic        last_byte = 1'b0;
	logic [15:0] udp_port = 16'd0;
	logic        is_ipv6 = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  msg_kind;
	logic        expire_valid;
	logic [31:0] expire_seconds;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = 32'd0;

	byte_req_t   payload_bytes[$];   // requests waiting to be offered
	result_t     classifications[$]; // results owed by the block, oldest first
	byte_req_t   cur_req;
	walk_t       ws;
	logic [31:0] expiry_default;
	int          mismatches = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	bit          running = 1'b0;

	// Directed datagrams: v6 kinds and rejects, v4 header limits, each message type, expiry
	// priority, PAD, END, wrong lengths, truncation and an option closing on the final byte.
	plan_row_t plan [25] = '{
		'{1'b1, PORT_V6_CLIENT, 9'd0, 1'b1, 6'd1, {V6_SOLICIT}, 1'b1,
			{KIND_SOLICIT, 1'b0, 32'd0}},
		'{1'b1, PORT_V6_SERVER, 9'd0, 1'b1, 6'd1, {V6_REPLY}, 1'b1,
			{KIND_REPLY, 1'b0, 32'd0}},
		'{1'b1, PORT_V6_SERVER, 9'd0, 1'b1, 6'd3, {V6_RENEW, OPT_END, OPT_PAD}, 1'b1,
			{KIND_RENEW, 1'b0, 32'd0}},
		'{1'b1, 16'd548, 9'd0, 1'b1, 6'd1, {V6_SOLICIT}, 1'b1, REJECTED},
		'{1'b1, 16'hFFFF, 9'd0, 1'b1, 6'd1, {V6_REPLY}, 1'b1, REJECTED},
		'{1'b1, PORT_V6_CLIENT, 9'd0, 1'b1, 6'd1, {8'hFF}, 1'b1, REJECTED},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd0, 256'd0, 1'b1,
			{KIND_NONE, 1'b1, DEFAULT_EXPIRE_RESET}},
		'{1'b0, PORT_V4_CLIENT, 9'd239, 1'b1, 6'd0, 256'd0, 1'b1, REJECTED},
		'{1'b0, PORT_V4_SERVER, 9'd1, 1'b1, 6'd0, 256'd0, 1'b1, REJECTED},
		'{1'b0, 16'd0, FULL_HDR, 1'b1, 6'd4, {OPT_MSG_TYPE, 8'd1, V4_ACK, OPT_END}, 1'b1,
			REJECTED},
		'{1'b0, PORT_V4_CLIENT, FULL_HDR, 1'b0, 6'd4, {OPT_MSG_TYPE, 8'd1, V4_ACK, OPT_END},
			1'b1, REJECTED},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd4, {OPT_MSG_TYPE, 8'd1, V4_ACK, OPT_END},
			1'b1, {KIND_ACK, 1'b1, DEFAULT_EXPIRE_RESET}},
		'{1'b0, PORT_V4_CLIENT, FULL_HDR, 1'b1, 6'd10, {OPT_MSG_TYPE, 8'd1, V4_DISCOVER,
			OPT_LEASE, TIME_OPT_LEN, 8'h00, 8'h00, 8'h0E, 8'h10, OPT_END}, 1'b0, '0},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd16, {OPT_MSG_TYPE, 8'd1, V4_OFFER,
			OPT_LEASE, TIME_OPT_LEN, 8'h00, 8'h01, 8'h51, 8'h80,
			OPT_REBIND, TIME_OPT_LEN, 8'h00, 8'h01, 8'h27, 8'h50, OPT_END}, 1'b0, '0},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd22, {OPT_MSG_TYPE, 8'd1, V4_REQUEST,
			OPT_LEASE, TIME_OPT_LEN, 8'hA1, 8'hB2, 8'hC3, 8'hD4,
			OPT_REBIND, TIME_OPT_LEN, 8'h12, 8'h34, 8'h56, 8'h78,
			OPT_RENEW, TIME_OPT_LEN, 8'h00, 8'h00, 8'h00, 8'h01, OPT_END}, 1'b0, '0},
		'{1'b0, PORT_V4_CLIENT, FULL_HDR, 1'b1, 6'd19, {
			OPT_RENEW, TIME_OPT_LEN, 8'h00, 8'h00, 8'h00, 8'h00,
			OPT_REBIND, TIME_OPT_LEN, 8'h00, 8'h00, 8'h00, 8'h00,
			OPT_LEASE, TIME_OPT_LEN, 8'h80, 8'h00, 8'h00, 8'h00, OPT_END}, 1'b0, '0},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd3, {OPT_MSG_TYPE, 8'd1, V4_ACK}, 1'b1,
			{KIND_NONE, 1'b1, DEFAULT_EXPIRE_RESET}},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd7, {OPT_PAD, OPT_PAD, OPT_MSG_TYPE, 8'd1,
			V4_OFFER, OPT_PAD, OPT_END}, 1'b0, '0},
		'{1'b0, PORT_V4_CLIENT, FULL_HDR, 1'b1, 6'd13, {OPT_LEASE, 8'd3, 8'h11, 8'h22, 8'h33,
			OPT_RENEW, 8'd5, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, OPT_END}, 1'b1,
			{KIND_NONE, 1'b1, DEFAULT_EXPIRE_RESET}},
		'{1'b0, PORT_V4_CLIENT, FULL_HDR, 1'b1, 6'd7, {OPT_MSG_TYPE, 8'd0, OPT_MSG_TYPE, 8'd2,
			V4_REQUEST, 8'h77, OPT_END}, 1'b0, '0},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd7, {OPT_MSG_TYPE, 8'd1, V4_DISCOVER,
			OPT_MSG_TYPE, 8'd1, V4_ACK, OPT_END}, 1'b0, '0},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd7, {OPT_MSG_TYPE, 8'd1, V4_ACK,
			OPT_LEASE, 8'd10, 8'h01, 8'h02}, 1'b0, '0},
		'{1'b0, PORT_V4_CLIENT, FULL_HDR, 1'b1, 6'd7, {OPT_MSG_TYPE, 8'd1, V4_DISCOVER,
			OPT_END, OPT_MSG_TYPE, 8'd1, V4_ACK}, 1'b0, '0},
		'{1'b0, PORT_V4_SERVER, FULL_HDR, 1'b1, 6'd7, {OPT_LEASE, TIME_OPT_LEN, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, OPT_END}, 1'b1, {KIND_NONE, 1'b1, 32'hFFFF_FFFF}},
		'{1'b0, PORT_V4_CLIENT, FULL_HDR, 1'b1, 6'd4, {OPT_MSG_TYPE, 8'd1, 8'd4, OPT_END}, 1'b1,
			{KIND_NONE, 1'b1, DEFAULT_EXPIRE_RESET}}
	};

	dhcp_message_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_value(byte_value),
		.last_byte(last_byte),
		.udp_port(udp_port),
		.is_ipv6(is_ipv6),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.msg_kind(msg_kind),
		.expire_valid(expire_valid),
		.expire_seconds(expire_seconds),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	function automatic void restart_walk();
		ws = '0;
		ws.ok = 1'b1;
		ws.step = PH_HEADER;
	endfunction

	// An option only takes effect when the walk reaches the next option code.
	function automatic void apply_option();
		if (ws.code == OPT_MSG_TYPE) begin
			if (ws.len != 8'd0)
				ws.mtype = ws.lead;
		end else if (ws.len == TIME_OPT_LEN) begin
			case (ws.code)
				OPT_LEASE:  ws.lease = ws.acc;
				OPT_REBIND: ws.rebind = ws.acc;
				OPT_RENEW:  ws.renew = ws.acc;
				default: ;
			endcase
		end
	endfunction

	function automatic void fold_v4_byte(input logic [7:0] b);
		logic [1:0] idx;
		idx = 2'(ws.pos - MAGIC_AT);
		case (ws.step)
			PH_HEADER: begin
				// last four header bytes must carry the cookie, most significant first
				if (ws.pos >= MAGIC_AT && b != COOKIE[8 * (3 - idx) +: 8])
					ws.ok = 1'b0;
				if (ws.pos == HDR_LAST_BYTE)
					ws.step = PH_CODE;
				else
					ws.pos = ws.pos + 8'd1;
			end
			PH_CODE: begin
				if (ws.pending) begin
					apply_option();
					ws.pending = 1'b0;
				end
				if (b == OPT_END) begin
					ws.step = PH_DONE;
				end else if (b != OPT_PAD) begin
					ws.code = b;
					ws.step = PH_LEN;
				end
			end
			PH_LEN: begin
				ws.len = b;
				ws.left_n = b;
				ws.acc = 32'd0;
				ws.lead = 8'd0;
				if (b == 8'd0) begin
					ws.pending = 1'b1;
					ws.step = PH_CODE;
				end else begin
					ws.step = PH_DATA;
				end
			end
			PH_DATA: begin
				if (ws.left_n == ws.len)
					ws.lead = b;
				ws.acc = {ws.acc[23:0], b};
				ws.left_n = ws.left_n - 8'd1;
				if (ws.left_n == 8'd0) begin
					ws.pending = 1'b1;
					ws.step = PH_CODE;
				end
			end
			default: ;
		endcase
	endfunction

	// Folds one accepted byte request in; returns 1 with the classification on a last byte.
	function automatic bit classify_byte(input byte_req_t r, output result_t res);
		res = '0;
		if (!ws.busy) begin
			// first byte: family and port are sampled here only
			restart_walk();
			ws.busy = 1'b1;
			ws.v6 = r.v6;
			if (r.v6) begin
				ws.ok = (r.port == PORT_V6_CLIENT || r.port == PORT_V6_SERVER);
				ws.mtype = r.b;
				ws.step = PH_DONE;
			end else begin
				ws.ok = (r.port == PORT_V4_SERVER || r.port == PORT_V4_CLIENT);
				fold_v4_byte(r.b);
			end
		end else if (!ws.v6) begin
			fold_v4_byte(r.b);
		end
		if (!r.last)
			return 1'b0;
		if (ws.v6) begin
			if (ws.ok) begin
				case (ws.mtype)
					V6_SOLICIT: res.msg_kind = KIND_SOLICIT;
					V6_REPLY:   res.msg_kind = KIND_REPLY;
					V6_RENEW:   res.msg_kind = KIND_RENEW;
					default:    res.msg_kind = KIND_NONE;
				endcase
			end
		end else if (ws.ok && ws.step != PH_HEADER) begin
			res.expire_valid = 1'b1;
			if (ws.renew != 32'd0)
				res.expire_seconds = ws.renew;
			else if (ws.rebind != 32'd0)
				res.expire_seconds = ws.rebind;
			else if (ws.lease != 32'd0)
				res.expire_seconds = ws.lease;
			else
				res.expire_seconds = expiry_default;
			case (ws.mtype)
				V4_ACK:      res.msg_kind = KIND_ACK;
				V4_DISCOVER: res.msg_kind = KIND_DISCOVER;
				V4_OFFER:    res.msg_kind = KIND_OFFER;
				V4_REQUEST:  res.msg_kind = KIND_REQUEST;
				default:     res.msg_kind = KIND_NONE;
			endcase
		end
		restart_walk();
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// Random BOOTP header of n bytes with the cookie at 236..239, optionally spoilt in one bit.
	task automatic add_header(ref logic [7:0] dg[$], input int n, input logic cookie_ok);
		int j;
		for (int k = 0; k < n; k++)
			dg.push_back(k >= MAGIC_AT ? COOKIE[8 * (239 - k) +: 8] : 8'($urandom));
		if (!cookie_ok && n == FULL_HDR) begin
			j = MAGIC_AT + $urandom_range(3);
			dg[j] = dg[j] ^ 8'(1 << $urandom_range(7));
		end
	endtask

	task automatic queue_datagram(input logic [7:0] dg[$], input logic [15:0] port,
			input logic v6, input logic typed, input result_t want);
		byte_req_t r;
		foreach (dg[k]) begin
			r.b = dg[k];
			r.last = (k == dg.size() - 1);
			r.port = port;
			r.v6 = v6;
			r.typed = typed;
			r.want = want;
			payload_bytes.push_back(r);
		end
	endtask

	// Block is idle once every request is in and every result is out; the result register
	// is loaded behind the input register, and a result is out once the checker has taken it.
	task automatic wait_idle();
		while (payload_bytes.size() != 0 || in_valid || classifications.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic flag_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// ---------------------------------------------------------------- byte sender

	// On an accepted request the predictor runs on it; a new request is only offered once the
	// current one has gone, so the payload never moves under a stall.
	always @(posedge clk) begin : feed
		result_t r;
		if (in_valid && !in_stall) begin
			if (classify_byte(cur_req, r))
				classifications.push_back(cur_req.typed ? cur_req.want : r);
		end
		if (!in_valid || !in_stall) begin
			if (running && payload_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
				cur_req = payload_bytes.pop_front();
				in_valid <= 1'b1;
				byte_value <= cur_req.b;
				last_byte <= cur_req.last;
				udp_port <= cur_req.port;
				is_ipv6 <= cur_req.v6;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- result checker

	always @(posedge clk) begin : collect
		result_t want;
		if (out_valid && !out_stall) begin
			if (classifications.size() == 0) begin
				flag_mismatch($sformatf("result with nothing owed: kind %0d valid %0d expire %0d",
					msg_kind, expire_valid, expire_seconds));
			end else begin
				want = classifications.pop_front();
				if (msg_kind !== want.msg_kind)
					flag_mismatch($sformatf("msg_kind %0d, predicted %0d",
						msg_kind, want.msg_kind));
				if (expire_valid !== want.expire_valid)
					flag_mismatch($sformatf("expire_valid %0d, predicted %0d",
						expire_valid, want.expire_valid));
				if (expire_seconds !== want.expire_seconds)
					flag_mismatch($sformatf("expire_seconds %0d, predicted %0d",
						expire_seconds, want.expire_seconds));
			end
		end
		out_stall <= running && ($urandom_range(99) < stall_pct);
	end

	// ---------------------------------------------------------------- run plan

	initial begin : run_plan
		logic [7:0]  dg[$];
		logic [15:0] port;
		logic [31:0] val;
		logic [7:0]  code;
		logic        v6;
		flaw_t       flaw;
		int          pick;
		int          len;
		int          n_dg;
		int          phase_bytes;

		restart_walk();
		expiry_default = DEFAULT_EXPIRE_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		// Directed table, at reset default expiry and with no idling.
		foreach (plan[i]) begin
			dg.delete();
			if (!plan[i].v6)
				add_header(dg, plan[i].hdr_len, plan[i].cookie_ok);
			for (int k = 0; k < plan[i].n_opt; k++)
				dg.push_back(plan[i].opts[8 * (plan[i].n_opt - 1 - k) +: 8]);
			queue_datagram(dg, plan[i].port, plan[i].v6, plan[i].typed, plan[i].want);
		end
		wait_idle();

		// Random phases: new default expiry each time, idle patterns in rotation.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       val = 32'd0;
				1:       val = 32'hFFFF_FFFF;
				2:       val = 32'd1;
				3:       val = 32'h8000_0000;
				4:       val = DEFAULT_EXPIRE_RESET;
				5:       val = 32'h7FFF_FFFF;
				default: val = $urandom();
			endcase
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= val;
			@(posedge clk);
			cfg_we <= 1'b0;
			expiry_default = val;

			case (phase % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 53; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 53; end
				default: begin gap_pct = 8; stall_pct = 8; end
			endcase

			n_dg = 0;
			phase_bytes = 0;
			while (n_dg < 10 && phase_bytes < 232) begin
				dg.delete();
				v6 = 1'b0;
				port = $urandom_range(1) ? PORT_V4_SERVER : PORT_V4_CLIENT;
				pick = $urandom_range(99);
				if (pick < 55 || (pick >= 70 && pick < 85)) begin
					// mostly well-formed DHCPv4; a share carries one defect
					flaw = (pick < 55) ? INTACT : flaw_t'($urandom_range(1, 3));
					if (flaw == WRONG_PORT)
						port = 16'($urandom);
					add_header(dg, flaw == SHORT ? $urandom_range(1, 239) : FULL_HDR,
						flaw != BAD_COOKIE);
					if (dg.size() == FULL_HDR) begin
						repeat ($urandom_range(0, 7)) begin
							case ($urandom_range(5))
								0: dg.push_back(OPT_PAD);
								1: begin
									len = $urandom_range(9) ? 1 : $urandom_range(0, 3);
									dg.push_back(OPT_MSG_TYPE);
									dg.push_back(8'(len));
									case ($urandom_range(4))
										0:       code = V4_DISCOVER;
										1:       code = V4_OFFER;
										2:       code = V4_REQUEST;
										3:       code = V4_ACK;
										default: code = 8'($urandom);
									endcase
									for (int k = 0; k < len; k++)
										dg.push_back(k == 0 ? code : 8'($urandom));
								end
								2, 3: begin
									case ($urandom_range(2))
										0:       code = OPT_LEASE;
										1:       code = OPT_RENEW;
										default: code = OPT_REBIND;
									endcase
									len = $urandom_range(9) ? TIME_OPT_LEN : $urandom_range(3, 5);
									case ($urandom_range(9))
										0, 1:    val = 32'd0;
										2:       val = 32'hFFFF_FFFF;
										default: val = $urandom();
									endcase
									dg.push_back(code);
									dg.push_back(8'(len));
									for (int k = 0; k < len; k++)
										dg.push_back(len == TIME_OPT_LEN ? val[8 * (3 - k) +: 8]
											: 8'($urandom));
								end
								default: begin
									// any other option, the known codes included by chance
									len = $urandom_range(0, 6);
									dg.push_back(8'($urandom_range(1, 254)));
									dg.push_back(8'(len));
									repeat (len) dg.push_back(8'($urandom));
								end
							endcase
						end
						// closing: END with trailing junk, nothing at all, or cut short
						case ($urandom_range(9))
							0, 1, 2, 3, 4, 5: begin
								dg.push_back(OPT_END);
								repeat ($urandom_range(0, 4)) dg.push_back(8'($urandom));
							end
							6, 7: ;
							default: begin
								repeat ($urandom_range(1, 3))
									if (dg.size() > 1)
										void'(dg.pop_back());
							end
						endcase
					end
				end else if (pick < 70) begin
					v6 = 1'b1;
					port = $urandom_range(9) ? ($urandom_range(1) ? PORT_V6_CLIENT
						: PORT_V6_SERVER) : 16'($urandom);
					case ($urandom_range(3))
						0:       dg.push_back(V6_SOLICIT);
						1:       dg.push_back(V6_REPLY);
						2:       dg.push_back(V6_RENEW);
						default: dg.push_back(8'($urandom));
					endcase
					repeat ($urandom_range(0, 4)) dg.push_back(8'($urandom));
				end else begin
					// noise: short random datagrams on any port and family
					v6 = 1'($urandom_range(1));
					port = 16'($urandom);
					repeat ($urandom_range(1, 24)) dg.push_back(8'($urandom));
				end
				queue_datagram(dg, port, v6, 1'b0, '0);
				n_dg++;
				phase_bytes += dg.size();
			end
			wait_idle();
		end

		gap_pct = 0;
		stall_pct = 0;
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

/* files.f */
rtl/core/dmc_pkg.sv
rtl/core/dmc_step.sv
rtl/core/dhcp_message_classifier.sv
test/testbench.sv
